// ===== hw/rtl/lrxo_pkg.sv =====
// lrxo_pkg: types, constants and fixed-point helpers of the crossover filter
// no dependencies; imported by linkwitz_riley_crossover_filter
package lrxo_pkg;

    typedef logic signed [23:0] sample_t;
    typedef logic signed [31:0] state_t;
    typedef logic signed [40:0] prod_t;
    typedef logic signed [43:0] wide_t;

    // configuration register indexes
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_COEF_G = 2'd1;
    localparam logic [1:0] REG_COEF_H = 2'd2;
    localparam logic [1:0] REG_DAMPING_R2 = 2'd3;

    // filter modes
    localparam logic [1:0] MODE_LOW = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_ALL = 2'd2;
    localparam logic [1:0] MODE_XOVER = 2'd3;

    localparam logic [31:0] COEF_G_RST = 32'd16777216;
    localparam logic [24:0] COEF_H_RST = 25'd5587456;
    localparam logic [25:0] DAMPING_R2_RST = 26'd23726566;

    // coefficient (24 fractional bits) times signal, rounded half up
    function automatic prod_t mulq(input logic [31:0] coef, input state_t v);
        logic signed [64:0] p;
        begin
            p = $signed({1'b0, coef}) * 65'(v);
            p = p + 65'sd8388608;
            mulq = prod_t'(p >>> 24);
        end
    endfunction

    function automatic state_t sat32(input wide_t v);
        begin
            if (v > 44'sd2147483647)
                sat32 = 32'sh7fffffff;
            else if (v < -44'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = state_t'(v);
        end
    endfunction

    function automatic sample_t sat24(input wide_t v);
        begin
            if (v > 44'sd8388607)
                sat24 = 24'sh7fffff;
            else if (v < -44'sd8388608)
                sat24 = 24'sh800000;
            else
                sat24 = sample_t'(v);
        end
    endfunction

endpackage

// ===== hw/rtl/lrxo_ram.sv =====
// lrxo_ram: generic single-write, single-read memory with registered read
// no dependencies; holds the per-channel integrator states
module lrxo_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/linkwitz_riley_crossover_filter.sv =====
// linkwitz_riley_crossover_filter: fourth-order crossover, sequencer and datapath
// depends on lrxo_pkg and lrxo_ram
//
// usage:
// - input channel: in_valid, in_stall, chan, sample_in. a word is taken when
//   in_valid is high and in_stall low; one word is in work at a time
// - output channel: out_valid, out_stall, first_out, second_out. a result
//   waits in the output register until taken, while the next word is accepted
// - config channel: cfg_valid, cfg_ready (always high), cfg_index, cfg_data;
//   write only while the block is idle
// - lowpass, highpass and crossover modes run the first and the second filter
//   stage, allpass mode only the first; a channel number out of range goes
//   straight to the output with zero results
// - a new word is taken only once the last is done: the single shared
//   multiplier runs ten steps per filter stage, plus state memory read and write
// - reset returns the control and configuration registers to their defaults
//   and clears the per-channel valid bits, so every channel starts with zero integrator state
// - a stalled receiver holds the result; the sequencer waits before loading a
//   new result into the output register
module linkwitz_riley_crossover_filter #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             chan,
    input  lrxo_pkg::sample_t      sample_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lrxo_pkg::sample_t      first_out,
    output lrxo_pkg::sample_t      second_out,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import lrxo_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [3:0] step_reg;
    logic stage_reg;
    logic skip_reg;
    logic [AW-1:0] addr_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;

    logic [1:0] mode_reg;
    logic [31:0] coef_g_reg;
    logic [24:0] coef_h_reg;
    logic [25:0] damping_r2_reg;

    state_t x_reg, b_reg, l_reg, t_reg, h_reg, bb_reg, ll_reg, nb_reg, nl_reg;
    state_t s1b_reg, s1l_reg, s2b_reg, s2l_reg;
    wide_t acc_reg, ap_reg;
    prod_t q_reg;

    logic out_valid_reg;
    sample_t first_reg, second_reg;

    logic [6:0] chan_ext;
    logic in_range;
    logic accept;
    logic ram_we;
    logic [127:0] ram_rdata;
    logic [31:0] mul_coef;
    state_t mul_v;
    state_t gy, gb, bb_new, ll_new;
    logic out_free;

    assign chan_ext = {4'b0, chan};
    assign in_range = chan_ext < 7'(NUM_CHANNELS);
    assign in_stall = state_reg != ST_IDLE;
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign first_out = first_reg;
    assign second_out = second_reg;
    assign ram_we = state_reg == ST_WRITE;
    assign out_free = !out_valid_reg || !out_stall;

    lrxo_ram #(
        .WIDTH(128),
        .DEPTH(NUM_CHANNELS)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(addr_reg),
        .wdata({s1b_reg, s1l_reg, s2b_reg, s2l_reg}),
        .re(accept),
        .raddr(chan_ext[AW-1:0]),
        .rdata(ram_rdata)
    );

    // multiplier operand select per step
    always_comb
    begin
        mul_coef = coef_g_reg;
        mul_v = b_reg;
        case (step_reg)
            4'd0: begin mul_coef = 32'(damping_r2_reg); mul_v = b_reg; end
            4'd1: begin mul_coef = coef_g_reg; mul_v = b_reg; end
            4'd3: begin mul_coef = 32'(coef_h_reg); mul_v = t_reg; end
            4'd5: begin mul_coef = coef_g_reg; mul_v = h_reg; end
            4'd7: begin mul_coef = coef_g_reg; mul_v = bb_reg; end
            4'd8: begin mul_coef = 32'(damping_r2_reg); mul_v = bb_reg; end
            default: begin mul_coef = coef_g_reg; mul_v = b_reg; end
        endcase
    end

    assign gy = sat32(wide_t'(q_reg));
    assign bb_new = sat32(wide_t'(gy) + wide_t'(b_reg));
    assign gb = sat32(wide_t'(q_reg));
    assign ll_new = sat32(wide_t'(gb) + wide_t'(l_reg));

    always_ff @(posedge clk)
    begin
        q_reg <= mulq(mul_coef, mul_v);
        if (accept)
        begin
            x_reg <= state_t'(sample_in);
            addr_reg <= chan_ext[AW-1:0];
        end
        if (state_reg == ST_LOAD)
        begin
            // entries never written since reset read as zero
            if (valid_reg[addr_reg])
            begin
                b_reg <= ram_rdata[127:96];
                l_reg <= ram_rdata[95:64];
                s2b_reg <= ram_rdata[63:32];
                s2l_reg <= ram_rdata[31:0];
            end
            else
            begin
                b_reg <= '0;
                l_reg <= '0;
                s2b_reg <= '0;
                s2l_reg <= '0;
            end
        end
        if (state_reg == ST_CALC)
        begin
            case (step_reg)
                4'd1: acc_reg <= wide_t'(x_reg) - wide_t'(q_reg) - wide_t'(l_reg);
                4'd2: t_reg <= sat32(acc_reg - wide_t'(q_reg));
                4'd4: h_reg <= sat32(wide_t'(q_reg));
                4'd6:
                begin
                    bb_reg <= bb_new;
                    nb_reg <= sat32(wide_t'(gy) + wide_t'(bb_new));
                end
                4'd8:
                begin
                    ll_reg <= ll_new;
                    nl_reg <= sat32(wide_t'(gb) + wide_t'(ll_new));
                end
                4'd9:
                begin
                    if (!stage_reg)
                    begin
                        ap_reg <= wide_t'(ll_reg) - wide_t'(q_reg) + wide_t'(h_reg);
                        s1b_reg <= nb_reg;
                        s1l_reg <= nl_reg;
                        x_reg <= (mode_reg == MODE_HIGH) ? h_reg : ll_reg;
                        b_reg <= s2b_reg;
                        l_reg <= s2l_reg;
                    end
                    else
                    begin
                        s2b_reg <= nb_reg;
                        s2l_reg <= nl_reg;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_DONE && out_free)
        begin
            if (skip_reg)
            begin
                first_reg <= '0;
                second_reg <= '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_LOW: first_reg <= sat24(wide_t'(ll_reg));
                    MODE_HIGH: first_reg <= sat24(wide_t'(h_reg));
                    MODE_ALL: first_reg <= sat24(ap_reg);
                    default: first_reg <= sat24(wide_t'(ll_reg));
                endcase
                second_reg <= (mode_reg == MODE_XOVER) ?
                    sat24(ap_reg - wide_t'(ll_reg)) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            stage_reg <= 1'b0;
            skip_reg <= 1'b0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            mode_reg <= MODE_LOW;
            coef_g_reg <= COEF_G_RST;
            coef_h_reg <= COEF_H_RST;
            damping_r2_reg <= DAMPING_R2_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_COEF_G: coef_g_reg <= cfg_data;
                    REG_COEF_H: coef_h_reg <= cfg_data[24:0];
                    REG_DAMPING_R2: damping_r2_reg <= cfg_data[25:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        skip_reg <= !in_range;
                        state_reg <= in_range ? ST_LOAD : ST_DONE;
                    end
                end
                ST_LOAD:
                begin
                    step_reg <= '0;
                    stage_reg <= 1'b0;
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (step_reg == 4'd9)
                    begin
                        step_reg <= '0;
                        stage_reg <= 1'b1;
                        // allpass leaves the second stage untouched
                        if (stage_reg || mode_reg == MODE_ALL)
                            state_reg <= ST_WRITE;
                    end
                    else
                        step_reg <= step_reg + 4'd1;
                end
                ST_WRITE:
                begin
                    valid_reg[addr_reg] <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
